### rtl/core/ubxfr_pkg.sv
package ubxfr_pkg;

    localparam logic [7:0] SYNC_FIRST   = 8'hB5;
    localparam logic [7:0] SYNC_SECOND  = 8'h62;
    localparam logic [7:0] LIMIT_RESET  = 8'd150;
    localparam logic [8:0] HEADER_BYTES = 9'd4;

    // Byte counts before the length-low and length-high bytes of the header.
    localparam logic [7:0] LEN_LOW_POS  = 8'd2;
    localparam logic [7:0] LEN_HIGH_POS = 8'd3;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } ubxfr_phase_t;

    typedef struct packed {
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       frame_done;
        logic [7:0] frame_length;
    } ubxfr_result_t;

endpackage

### rtl/core/ubxfr_ifs.sv
interface ubxfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ubxfr_store_if;
    logic       valid;
    logic       ready;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       frame_done;
    logic [7:0] frame_length;

    modport source (
        output valid, output store_index, output store_byte,
        output frame_done, output frame_length, input ready
    );
    modport sink (
        input valid, input store_index, input store_byte,
        input frame_done, input frame_length, output ready
    );
endinterface

### rtl/core/ubxfr_parser.sv
module ubxfr_parser import ubxfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    length_limit,
    input  logic          advance,
    input  logic [7:0]    rx_byte,
    output ubxfr_result_t result
);

    ubxfr_phase_t phase_reg, phase_next;
    logic [7:0]   byte_count_reg, byte_count_next;
    logic [7:0]   length_low_reg, length_low_next;
    logic [7:0]   total_length_reg, total_length_next;
    logic [7:0]   sum_a_reg, sum_a_next;
    logic [7:0]   sum_b_reg, sum_b_next;

    logic [7:0] count_inc;
    logic [7:0] sum_a_add;
    logic [7:0] sum_b_add;
    logic [8:0] length_sum;
    logic       length_ok;

    assign count_inc  = byte_count_reg + 8'd1;
    assign sum_a_add  = sum_a_reg + rx_byte;
    assign sum_b_add  = sum_b_reg + sum_a_add;
    assign length_sum = {1'b0, length_low_reg} + HEADER_BYTES;

    // The limit is at most 255, so any nonzero high length byte fails the check.
    assign length_ok = (rx_byte == 8'd0) && (length_low_reg != 8'd0)
                     && (length_sum < {1'b0, length_limit});

    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = count_inc;
        length_low_next   = length_low_reg;
        total_length_next = total_length_reg;
        sum_a_next        = sum_a_reg;
        sum_b_next        = sum_b_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (byte_count_reg == 8'd0)
                begin
                    if (rx_byte != SYNC_FIRST)
                    begin
                        byte_count_next = 8'd0;
                    end
                end
                else
                begin
                    byte_count_next = 8'd0;
                    if (rx_byte == SYNC_SECOND)
                    begin
                        phase_next = PH_HEADER;
                        sum_a_next = 8'd0;
                        sum_b_next = 8'd0;
                    end
                end
            end
            PH_HEADER:
            begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                if (byte_count_reg == LEN_LOW_POS)
                begin
                    length_low_next = rx_byte;
                end
                if (byte_count_reg == LEN_HIGH_POS)
                begin
                    if (length_ok)
                    begin
                        total_length_next = length_sum[7:0];
                        phase_next        = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next      = PH_HUNT;
                        byte_count_next = 8'd0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                if (count_inc == total_length_reg)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                if ((byte_count_reg != total_length_reg) || (rx_byte != sum_a_reg))
                begin
                    phase_next      = PH_HUNT;
                    byte_count_next = 8'd0;
                end
            end
            default:
            begin
                phase_next      = PH_HUNT;
                byte_count_next = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        result.store_index  = byte_count_reg;
        result.store_byte   = rx_byte;
        result.frame_done   = 1'b0;
        result.frame_length = 8'd0;
        case (phase_reg)
            PH_CHECK:
            begin
                if ((byte_count_reg != total_length_reg) && (rx_byte == sum_b_reg))
                begin
                    result.frame_done   = 1'b1;
                    result.frame_length = total_length_reg;
                end
            end
            default:
            begin
                result.frame_done   = 1'b0;
                result.frame_length = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            byte_count_reg   <= 8'd0;
            length_low_reg   <= 8'd0;
            total_length_reg <= 8'd0;
            sum_a_reg        <= 8'd0;
            sum_b_reg        <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            length_low_reg   <= length_low_next;
            total_length_reg <= total_length_next;
            sum_a_reg        <= sum_a_next;
            sum_b_reg        <= sum_b_next;
        end
    end

endmodule

### rtl/core/ubx_frame_receiver.sv
// Receives a UBX byte stream one byte per transfer and emits one result per byte: the frame
// memory index to store the byte at, the byte itself, and a frame-done flag with the total
// length (payload plus four) on a second checksum byte that completes a frame whose Fletcher
// sums both match. The block sustains one byte per clock cycle while the output side is not
// stalled; each byte passes an input register and then a result register before its result
// is offered. The length limit must be written only while no byte is in flight.
module ubx_frame_receiver import ubxfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    ubxfr_byte_if.sink    byte_ch,
    ubxfr_store_if.source store_ch
);

    logic [7:0]    length_limit_reg;
    logic          hold_valid_reg;
    logic [7:0]    hold_byte_reg;
    logic          out_valid_reg;
    ubxfr_result_t out_result_reg;
    ubxfr_result_t result;
    logic          advance;
    logic          in_take;

    assign advance       = hold_valid_reg && (!out_valid_reg || store_ch.ready);
    assign byte_ch.ready = !hold_valid_reg || advance;
    assign in_take       = byte_ch.valid && byte_ch.ready;

    ubxfr_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .length_limit (length_limit_reg),
        .advance      (advance),
        .rx_byte      (hold_byte_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_limit_reg <= LIMIT_RESET;
            hold_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                length_limit_reg <= cfg_wr_data;
            end
            if (in_take)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (store_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hold_byte_reg <= byte_ch.rx_byte;
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign store_ch.valid        = out_valid_reg;
    assign store_ch.store_index  = out_result_reg.store_index;
    assign store_ch.store_byte   = out_result_reg.store_byte;
    assign store_ch.frame_done   = out_result_reg.frame_done;
    assign store_ch.frame_length = out_result_reg.frame_length;

`ifndef SYNTHESIS
    a_len_zero_without_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_result_reg.frame_done |-> out_result_reg.frame_length == 8'd0
    ) else $error("frame length reported without a completed frame");

    a_done_length_min: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.frame_done |-> out_result_reg.frame_length > 8'd4
    ) else $error("completed frame with a total length of four or less");

    a_advance_fills_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg
    ) else $error("result register empty after a transfer from the input register");

    a_hold_keeps_byte: assert property (
        @(posedge clk) disable iff (!rst_n)
        hold_valid_reg && !advance |=> hold_valid_reg && $stable(hold_byte_reg)
    ) else $error("stalled input register lost its byte");
`endif

endmodule

### tb/tb_ubx_frame_receiver.sv
module tb_ubx_frame_receiver;
    import ubxfr_pkg::*;

    localparam int FAULT_NONE  = 0;
    localparam int FAULT_CKA   = 1;
    localparam int FAULT_CKB   = 2;
    localparam int FAULT_SYNC  = 3;
    localparam int FAULT_NOISE = 4;

    localparam int SETTLE_CYCLES = 8;
    localparam int HANG_LIMIT    = 2000;
    localparam int PHASE_BYTES   = 85;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    ubxfr_byte_if  byte_if ();
    ubxfr_store_if store_if ();

    ubx_frame_receiver i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .byte_ch    (byte_if),
        .store_ch   (store_if)
    );

    // Parser state mirrored by the testbench.
    ubxfr_phase_t rx_phase;
    logic [8:0]   rx_count;
    logic [7:0]   rx_len_low;
    logic [7:0]   rx_total;
    logic [7:0]   rx_sum_a;
    logic [7:0]   rx_sum_b;
    logic [7:0]   rx_limit;

    logic [7:0]    tx_bytes[$];
    ubxfr_result_t expected_stores[$];

    int bytes_queued;
    int results_seen;
    int errors;
    int src_gap;
    bit src_idle_on;
    int snk_stall;
    int snk_wait;
    bit snk_stall_on;
    int hang_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic ubxfr_result_t parse_byte(input logic [7:0] b);
        ubxfr_result_t res;
        logic [8:0]    cnt;
        logic [16:0]   total17;
        res = '0;
        res.store_index = rx_count[7:0];
        res.store_byte = b;
        rx_count = rx_count + 9'd1;
        cnt = rx_count;
        case (rx_phase)
            PH_HUNT:
            begin
                if (cnt == 9'd1)
                begin
                    if (b != SYNC_FIRST)
                        rx_count = '0;
                end
                else if (b == SYNC_SECOND)
                begin
                    rx_phase = PH_HEADER;
                    rx_count = '0;
                    rx_sum_a = '0;
                    rx_sum_b = '0;
                end
                else
                    rx_count = '0;
            end
            PH_HEADER:
            begin
                rx_sum_a = rx_sum_a + b;
                rx_sum_b = rx_sum_b + rx_sum_a;
                if (res.store_index == LEN_LOW_POS)
                    rx_len_low = b;
                if (res.store_index == LEN_HIGH_POS)
                begin
                    total17 = {1'b0, b, rx_len_low} + 17'(HEADER_BYTES);
                    if (total17 > 17'(HEADER_BYTES) && total17 < {9'd0, rx_limit})
                    begin
                        rx_total = total17[7:0];
                        rx_phase = PH_PAYLOAD;
                    end
                    else
                    begin
                        rx_phase = PH_HUNT;
                        rx_count = '0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                rx_sum_a = rx_sum_a + b;
                rx_sum_b = rx_sum_b + rx_sum_a;
                if (cnt == {1'b0, rx_total})
                    rx_phase = PH_CHECK;
            end
            default:
            begin
                if (cnt == {1'b0, rx_total} + 9'd1)
                begin
                    if (b != rx_sum_a)
                    begin
                        rx_phase = PH_HUNT;
                        rx_count = '0;
                    end
                end
                else
                begin
                    rx_phase = PH_HUNT;
                    rx_count = '0;
                    if (b == rx_sum_b)
                    begin
                        res.frame_done = 1'b1;
                        res.frame_length = rx_total;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Queues one frame. Rejected headers are followed only by the checksum bytes,
    // which then land in the sync hunt.
    task automatic add_frame(input logic [7:0] cls, input logic [7:0] msg_id,
                             input int stated, input int fault);
        logic [7:0] hdr[4];
        logic [7:0] sa;
        logic [7:0] sb;
        logic [7:0] p;
        int         n_payload;
        int         total;
        hdr[0] = cls;
        hdr[1] = msg_id;
        hdr[2] = stated[7:0];
        hdr[3] = stated[15:8];
        sa = '0;
        sb = '0;
        total = stated + 4;
        n_payload = (total > 4 && total < int'(rx_limit)) ? stated : 0;
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        for (int i = 0; i < 4; i++)
        begin
            push_byte(hdr[i]);
            sa = sa + hdr[i];
            sb = sb + sa;
        end
        for (int i = 0; i < n_payload; i++)
        begin
            p = 8'($urandom_range(0, 255));
            push_byte(p);
            sa = sa + p;
            sb = sb + sa;
        end
        push_byte(fault == FAULT_CKA ? sa ^ 8'($urandom_range(1, 255)) : sa);
        push_byte(fault == FAULT_CKB ? sb ^ 8'($urandom_range(1, 255)) : sb);
    endtask

    task automatic random_traffic(input int budget);
        int start;
        int r;
        int stated;
        int fault;
        start = bytes_queued;
        while (bytes_queued - start < budget)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                stated = int'(rx_limit) - 5;
            else if (r == 1)
                stated = int'(rx_limit) - 4;
            else if (r == 2)
                stated = $urandom_range(0, 65535);
            else
                stated = $urandom_range(0, 12);
            if (stated < 0)
                stated = 0;
            r = $urandom_range(0, 19);
            if (r < 14)
                fault = FAULT_NONE;
            else if (r < 16)
                fault = FAULT_CKA;
            else if (r < 18)
                fault = FAULT_CKB;
            else if (r < 19)
                fault = FAULT_SYNC;
            else
                fault = FAULT_NOISE;
            if (fault == FAULT_SYNC)
            begin
                push_byte(SYNC_FIRST);
                push_byte(8'($urandom_range(0, 255)));
            end
            else if (fault == FAULT_NOISE)
            begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)));
            end
            else
                add_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          stated, fault);
        end
    endtask

    task automatic drain();
        while (results_seen < bytes_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        drain();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        rx_limit = value;
    endtask

    // Byte sender. The gap drawn when a byte is presented applies after its transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_if.valid <= 1'b0;
            byte_if.rx_byte <= '0;
            src_gap <= 0;
            src_idle_on = 1'b1;
            rx_phase = PH_HUNT;
            rx_count = '0;
            rx_len_low = '0;
            rx_total = '0;
            rx_sum_a = '0;
            rx_sum_b = '0;
        end
        else
        begin
            if (byte_if.valid && byte_if.ready)
                expected_stores.push_back(parse_byte(byte_if.rx_byte));
            if (!byte_if.valid || byte_if.ready)
            begin
                if (src_gap > 0)
                begin
                    byte_if.valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end
                else if (tx_bytes.size() > 0)
                begin
                    byte_if.valid <= 1'b1;
                    byte_if.rx_byte <= tx_bytes.pop_front();
                    if ($urandom_range(0, 39) == 0)
                        src_idle_on = !src_idle_on;
                    src_gap <= src_idle_on ? int'($urandom_range(0, 7)) : 0;
                end
                else
                    byte_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver and checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_if.ready <= 1'b0;
            snk_stall <= 0;
            snk_stall_on = 1'b1;
        end
        else if (store_if.valid && store_if.ready)
        begin
            results_seen++;
            if (expected_stores.size() == 0)
                report($sformatf("unexpected result index %0d byte 0x%02h",
                                 store_if.store_index, store_if.store_byte));
            else
            begin
                ubxfr_result_t want;
                want = expected_stores.pop_front();
                if (store_if.store_index !== want.store_index)
                    report($sformatf("store_index %0d, expected %0d",
                                     store_if.store_index, want.store_index));
                if (store_if.store_byte !== want.store_byte)
                    report($sformatf("store_byte 0x%02h, expected 0x%02h",
                                     store_if.store_byte, want.store_byte));
                if (store_if.frame_done !== want.frame_done)
                    report($sformatf("frame_done %0b, expected %0b",
                                     store_if.frame_done, want.frame_done));
                if (store_if.frame_length !== want.frame_length)
                    report($sformatf("frame_length %0d, expected %0d",
                                     store_if.frame_length, want.frame_length));
            end
            if ($urandom_range(0, 39) == 0)
                snk_stall_on = !snk_stall_on;
            snk_wait = snk_stall_on ? int'($urandom_range(0, 7)) : 0;
            snk_stall <= snk_wait;
            store_if.ready <= (snk_wait == 0);
        end
        else if (snk_stall > 0)
        begin
            snk_stall <= snk_stall - 1;
            store_if.ready <= (snk_stall == 1);
        end
        else
            store_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_if.valid && byte_if.ready) || (store_if.valid && store_if.ready))
                hang_cycles <= 0;
            else if (hang_cycles >= HANG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                hang_cycles <= hang_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        bytes_queued = 0;
        rx_limit = LIMIT_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // A repeated first sync byte restarts the hunt, then extreme byte values.
        push_byte(SYNC_FIRST);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(8'h00);
        push_byte(8'hFF);
        add_frame(8'h00, 8'hFF, 1, FAULT_NONE);
        add_frame(8'hFF, 8'h00, 0, FAULT_NONE);
        add_frame(8'h01, 8'h02, 256, FAULT_NONE);
        add_frame(8'h05, 8'h01, 1, FAULT_CKA);
        add_frame(8'h05, 8'h01, 1, FAULT_CKB);
        add_frame(8'h0A, 8'h0B, 146, FAULT_NONE);

        random_traffic(PHASE_BYTES);

        // The sender holds off until the pipeline has emptied before each new limit.
        write_limit(8'd255);
        random_traffic(PHASE_BYTES);
        write_limit(8'd6);
        random_traffic(PHASE_BYTES);
        write_limit(8'd5);
        random_traffic(PHASE_BYTES / 2);
        write_limit(8'd0);
        random_traffic(PHASE_BYTES / 2);
        write_limit(8'd20);
        random_traffic(PHASE_BYTES);
        write_limit(8'($urandom_range(6, 255)));
        random_traffic(PHASE_BYTES);
        write_limit(LIMIT_RESET);
        random_traffic(PHASE_BYTES);

        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
